// ===== rtl/circle_fit_checker_unit_macros.svh =====
//----------------------------------------------------------------------------
// Circle fit checker assertion macros
// Clocked assertion wrappers used by the core of the unit.
//----------------------------------------------------------------------------
`ifndef CIRCLE_FIT_CHECKER_UNIT_MACROS_SVH
`define CIRCLE_FIT_CHECKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication on clk, muted during rst
`define CFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk, muted during rst
`define CFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFC_ASSERT_IMPL(lbl, ante, cons, msg)
`define CFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cfc_pkg.sv =====
//----------------------------------------------------------------------------
// Circle fit checker package
// Widths, codes and shared types of the circle fit checker.
//----------------------------------------------------------------------------
package cfc_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS     = 65535;
  localparam int FRAC_BITS      = 8;

  localparam int MIN_SET_POINTS = 8;
  localparam int REL_FRAC       = 14;
  localparam int MINDEV_FRAC    = 8;
  localparam int REL_BITS       = 16;
  localparam int MINDEV_BITS    = 24;
  localparam int SUM_BITS       = 48;
  localparam int REL_LIMIT_RESET = 1638;

  localparam int C2_BITS       = COORD_BITS + 1;
  localparam int D_BITS        = COORD_BITS + 1;
  localparam int SQ_BITS       = 2 * D_BITS + 1;
  localparam int EXTRA         = FRAC_BITS - 1;
  localparam int RADICAND_BITS = ((SQ_BITS + 2 * EXTRA + 1) / 2) * 2;
  localparam int ROOT_BITS     = RADICAND_BITS / 2;
  localparam int RAD_BITS      = COORD_BITS + FRAC_BITS - 1;
  localparam int MEAN_BITS     = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_BITS      = $clog2(MAX_POINTS + 2);
  localparam int MUL_BITS      = (COORD_BITS + 2 > REL_BITS) ? COORD_BITS + 2 : REL_BITS;
  localparam int PROD_BITS     = 2 * MUL_BITS;
  localparam int UNIT_BITS     = (ROOT_BITS + 2 > CNT_BITS + 1) ? ROOT_BITS + 2 : CNT_BITS + 1;
  localparam int STEP_BITS     = $clog2((SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS);
  localparam int CMP_BITS      = (SUM_BITS + REL_FRAC + 1 > PROD_BITS + FRAC_BITS) ?
                                 SUM_BITS + REL_FRAC + 1 : PROD_BITS + FRAC_BITS;

  localparam int IDX_BITS      = 3;
  localparam int CFG_DATA_BITS = (COORD_BITS > MINDEV_BITS) ? COORD_BITS : MINDEV_BITS;
  localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * C2_BITS + RAD_BITS + MEAN_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 2;

  typedef enum logic [OUT_USER_BITS-1:0] {
    ST_FIT  = 2'd0,
    ST_OVER = 2'd1,
    ST_FEW  = 2'd2,
    ST_MANY = 2'd3
  } status_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_REL    = 3'd4,
    REG_MINDEV = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [C2_BITS-1:0]     cx2;
    logic [C2_BITS-1:0]     cy2;
    logic [C2_BITS-1:0]     span;
    logic                   geom_ok;
    logic [REL_BITS-1:0]    rel_limit;
    logic [MINDEV_BITS-1:0] min_deviation;
  } cfg_t;

  typedef struct packed {
    status_t               status;
    logic [C2_BITS-1:0]    cx2;
    logic [C2_BITS-1:0]    cy2;
    logic [RAD_BITS-1:0]   radius;
    logic [MEAN_BITS-1:0]  mean;
  } res_t;

endpackage

// ===== rtl/cfc_cfg.sv =====
//----------------------------------------------------------------------------
// Circle fit checker configuration registers
// Holds the rectangle and limit registers and derives the circle geometry.
//----------------------------------------------------------------------------
module cfc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [cfc_pkg::IDX_BITS-1:0]      wr_index,
  input  logic [cfc_pkg::CFG_DATA_BITS-1:0] wr_data,
  output cfc_pkg::cfg_t                     cfg
);
  import cfc_pkg::*;

  logic [COORD_BITS-1:0]  rect_left;
  logic [COORD_BITS-1:0]  rect_top;
  logic [COORD_BITS-1:0]  rect_right;
  logic [COORD_BITS-1:0]  rect_bottom;
  logic [REL_BITS-1:0]    rel_limit;
  logic [MINDEV_BITS-1:0] min_deviation;
  logic                   wide_ok;
  logic                   high_ok;
  logic [COORD_BITS-1:0]  w;
  logic [COORD_BITS-1:0]  h;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_right    <= '0;
      rect_bottom   <= '0;
      rel_limit     <= REL_BITS'(REL_LIMIT_RESET);
      min_deviation <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LEFT:   rect_left     <= wr_data[COORD_BITS-1:0];
        REG_TOP:    rect_top      <= wr_data[COORD_BITS-1:0];
        REG_RIGHT:  rect_right    <= wr_data[COORD_BITS-1:0];
        REG_BOTTOM: rect_bottom   <= wr_data[COORD_BITS-1:0];
        REG_REL:    rel_limit     <= wr_data[REL_BITS-1:0];
        REG_MINDEV: min_deviation <= wr_data[MINDEV_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign wide_ok = {1'b0, rect_right} > ({1'b0, rect_left} + C2_BITS'(1));
  assign high_ok = {1'b0, rect_bottom} > ({1'b0, rect_top} + C2_BITS'(1));
  assign w       = rect_right - rect_left;
  assign h       = rect_bottom - rect_top;

  assign cfg.cx2           = {1'b0, rect_left} + {1'b0, rect_right};
  assign cfg.cy2           = {1'b0, rect_top} + {1'b0, rect_bottom};
  assign cfg.span          = {1'b0, w} + {1'b0, h};
  assign cfg.geom_ok       = wide_ok && high_ok;
  assign cfg.rel_limit     = rel_limit;
  assign cfg.min_deviation = min_deviation;

endmodule

// ===== rtl/cfc_cmpsub.sv =====
//----------------------------------------------------------------------------
// Circle fit checker compare and subtract unit
// Shared trial subtraction of the square root and division steps.
//----------------------------------------------------------------------------
module cfc_cmpsub (
  input  logic [cfc_pkg::UNIT_BITS-1:0] a,
  input  logic [cfc_pkg::UNIT_BITS-1:0] b,
  output logic                          ge,
  output logic [cfc_pkg::UNIT_BITS-1:0] diff
);
  import cfc_pkg::*;

  logic [UNIT_BITS:0] wide_diff;

  assign wide_diff = {1'b0, a} - {1'b0, b};
  assign ge        = !wide_diff[UNIT_BITS];
  assign diff      = wide_diff[UNIT_BITS-1:0];

endmodule

// ===== rtl/cfc_core.sv =====
//----------------------------------------------------------------------------
// Circle fit checker core
// Sequencer with one multiplier and one shared compare and subtract unit:
// squares, digit-serial square root, deviation sum, division and limit test.
//----------------------------------------------------------------------------
`include "circle_fit_checker_unit_macros.svh"

module cfc_core (
  input  logic                           clk,
  input  logic                           rst,
  input  cfc_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cfc_pkg::COORD_BITS-1:0] in_x,
  input  logic [cfc_pkg::COORD_BITS-1:0] in_y,
  input  logic                           in_last,
  output logic                           res_valid,
  input  logic                           res_ready,
  output cfc_pkg::res_t                  res
);
  import cfc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SQX  = 10'b0000000010,
    S_SQY  = 10'b0000000100,
    S_SUM  = 10'b0000001000,
    S_ROOT = 10'b0000010000,
    S_DEV  = 10'b0000100000,
    S_ADD  = 10'b0001000000,
    S_LIM  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_CHK  = 10'b1000000000
  } state_t;

  state_t                   state;
  logic                     out_pend;
  logic [D_BITS-1:0]        dx;
  logic [D_BITS-1:0]        dy;
  logic                     last;
  logic [PROD_BITS-1:0]     prod;
  logic [2*D_BITS-1:0]      acc;
  logic [RADICAND_BITS-1:0] radicand;
  logic [ROOT_BITS-1:0]     root;
  logic [UNIT_BITS-1:0]     rem;
  logic [STEP_BITS-1:0]     step;
  logic [ROOT_BITS-1:0]     dev;
  logic [SUM_BITS-1:0]      deviation_sum;
  logic [CNT_BITS-1:0]      points_seen;
  status_t                  status;
  logic [RAD_BITS-1:0]      radius;
  logic [MEAN_BITS-1:0]     mean;

  logic [MUL_BITS-1:0]      mul_a;
  logic [MUL_BITS-1:0]      mul_b;
  logic [PROD_BITS-1:0]     mul_p;
  logic [UNIT_BITS-1:0]     unit_a;
  logic [UNIT_BITS-1:0]     unit_b;
  logic                     unit_ge;
  logic [UNIT_BITS-1:0]     unit_diff;
  logic [SQ_BITS-1:0]       sq_sum;
  logic [RAD_BITS-1:0]      radius_val;
  logic [ROOT_BITS-1:0]     rad_ext;
  logic [SUM_BITS:0]        sum_ext;
  logic                     over_rel;
  logic                     over_min;

  function automatic logic [D_BITS-1:0] absdiff_d(input logic [D_BITS-1:0] a,
                                                  input logic [D_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  always_comb begin
    case (state)
      S_SQX: begin
        mul_a = MUL_BITS'(dx);
        mul_b = MUL_BITS'(dx);
      end
      S_SQY: begin
        mul_a = MUL_BITS'(dy);
        mul_b = MUL_BITS'(dy);
      end
      default: begin
        mul_a = MUL_BITS'(cfg.rel_limit);
        mul_b = MUL_BITS'(cfg.span) + MUL_BITS'(2);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (state == S_ROOT) begin
      unit_a = {rem[UNIT_BITS-3:0], radicand[RADICAND_BITS-1 -: 2]};
      unit_b = UNIT_BITS'({root, 2'b01});
    end else begin
      unit_a = {rem[UNIT_BITS-2:0], deviation_sum[SUM_BITS-1]};
      unit_b = UNIT_BITS'(points_seen);
    end
  end

  cfc_cmpsub u_cmpsub (
    .a    (unit_a),
    .b    (unit_b),
    .ge   (unit_ge),
    .diff (unit_diff)
  );

  assign sq_sum     = {1'b0, acc} + {1'b0, prod[2*D_BITS-1:0]};
  assign radius_val = {cfg.span, {(FRAC_BITS-2){1'b0}}};
  assign rad_ext    = ROOT_BITS'(radius_val);
  assign sum_ext    = {1'b0, deviation_sum} + (SUM_BITS+1)'(dev);
  assign over_rel   = CMP_BITS'({deviation_sum, {(REL_FRAC+1){1'b0}}}) >
                      CMP_BITS'({prod, {FRAC_BITS{1'b0}}});
  assign over_min   = CMP_BITS'({deviation_sum, {MINDEV_FRAC{1'b0}}}) >
                      CMP_BITS'({cfg.min_deviation, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_pend      <= 1'b0;
      step          <= '0;
      deviation_sum <= '0;
      points_seen   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_pend) begin
            if (res_ready) begin
              out_pend      <= 1'b0;
              deviation_sum <= '0;
              points_seen   <= '0;
            end
          end else if (in_valid) begin
            dx    <= absdiff_d(cfg.cx2, {in_x, 1'b0});
            dy    <= absdiff_d(cfg.cy2, {in_y, 1'b0});
            last  <= in_last;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          prod  <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          acc   <= prod[2*D_BITS-1:0];
          prod  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          radicand <= RADICAND_BITS'({sq_sum, {(2*EXTRA){1'b0}}});
          root     <= '0;
          rem      <= '0;
          step     <= '0;
          state    <= S_ROOT;
        end
        S_ROOT: begin
          rem      <= unit_ge ? unit_diff : unit_a;
          root     <= {root[ROOT_BITS-2:0], unit_ge};
          radicand <= radicand << 2;
          step     <= step + 1'b1;
          if (step == STEP_BITS'(ROOT_BITS - 1)) begin
            state <= S_DEV;
          end
        end
        S_DEV: begin
          dev   <= (root >= rad_ext) ? root - rad_ext : rad_ext - root;
          state <= S_ADD;
        end
        S_ADD: begin
          if (cfg.geom_ok) begin
            deviation_sum <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
          end
          if (points_seen <= CNT_BITS'(MAX_POINTS)) begin
            points_seen <= points_seen + 1'b1;
          end
          state <= last ? S_LIM : S_IDLE;
        end
        S_LIM: begin
          prod <= mul_p;
          rem  <= '0;
          step <= '0;
          if (points_seen > CNT_BITS'(MAX_POINTS)) begin
            status   <= ST_MANY;
            radius   <= '0;
            mean     <= '0;
            out_pend <= 1'b1;
            state    <= S_IDLE;
          end else if (points_seen < CNT_BITS'(MIN_SET_POINTS) || !cfg.geom_ok) begin
            status   <= ST_FEW;
            radius   <= '0;
            mean     <= '0;
            out_pend <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem           <= unit_ge ? unit_diff : unit_a;
          deviation_sum <= {deviation_sum[SUM_BITS-2:0], unit_ge};
          step          <= step + 1'b1;
          if (step == STEP_BITS'(SUM_BITS - 1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          status   <= (over_rel && over_min) ? ST_OVER : ST_FIT;
          radius   <= radius_val;
          mean     <= (|deviation_sum[SUM_BITS-1:MEAN_BITS]) ? '1 :
                      deviation_sum[MEAN_BITS-1:0];
          out_pend <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE) && !out_pend;
  assign res_valid  = out_pend;
  assign res.status = status;
  assign res.cx2    = cfg.cx2;
  assign res.cy2    = cfg.cy2;
  assign res.radius = radius;
  assign res.mean   = mean;

  `CFC_ASSERT_IMPL(a_cnt_bound, 1'b1, points_seen <= CNT_BITS'(MAX_POINTS + 1), "point count past saturation")
  `CFC_ASSERT_NEXT(a_clear_set, res_valid && res_ready, points_seen == '0 && deviation_sum == '0, "set state not cleared after result")
  `CFC_ASSERT_IMPL(a_fail_zero, res_valid && (res.status == ST_FEW || res.status == ST_MANY), res.radius == '0 && res.mean == '0, "failed set reports radius or mean")
  `CFC_ASSERT_IMPL(a_root_steps, state == S_ROOT, step < STEP_BITS'(ROOT_BITS), "square root ran past its digits")

endmodule

// ===== rtl/circle_fit_checker_unit.sv =====
//----------------------------------------------------------------------------
// Circle fit checker unit
// Checks a stream of blob edge points against the circle of the configured
// bounding rectangle and reports centre, radius, mean deviation and status.
//----------------------------------------------------------------------------
// Usage:
//   cfg_*    : register writes, index 0..5 = left, top, right, bottom,
//              rel_limit, min_deviation; always ready; write only when idle.
//   s_axis_* : one edge point per transaction, tlast marks the final point.
//   m_axis_* : one result per point set, issued after the tlast point.
// Points: s_axis_tready is low while a point is processed and while a result
//   is held, so a new point waits for the last: two squares, ROOT_BITS (25)
//   digit steps of the shared compare and subtract unit and the update.
// Result: the tlast point adds a limit product and, for a set that passes the
//   count and geometry tests, SUM_BITS (48) division steps on the same unit
//   and a check; the result then passes through the output register.
// Reset: rst clears the point count, deviation sum and any held result;
//   registers return to zero, rel_limit to 1638.
// Stall: a result is held in the output register while m_axis_tready is low;
//   the core holds its next result, and takes no new point until it is free.
//----------------------------------------------------------------------------
module circle_fit_checker_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfc_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [cfc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_y
  input  logic [cfc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // center_x2, center_y2, radius_q8, mean_deviation_q8
  output logic [cfc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // status
  output logic [cfc_pkg::OUT_USER_BITS-1:0]   m_axis_tuser
);
  import cfc_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic core_valid;
  logic core_ready;

  assign cfg_ready = 1'b1;

  cfc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cfc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_x      (s_axis_tdata[COORD_BITS-1:0]),
    .in_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_last   (s_axis_tlast),
    .res_valid (core_valid),
    .res_ready (core_ready),
    .res       (core_res)
  );

  assign core_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (core_ready) begin
      m_axis_tvalid <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = OUT_DATA_BITS'({out_res.mean, out_res.radius,
                                        out_res.cy2, out_res.cx2});
  assign m_axis_tuser = out_res.status;

endmodule

// ===== tb/circle_fit_result_checker.sv =====
`timescale 1ns / 100ps
//----------------------------------------------------------------------------
// Circle fit result checker
// Follows the register, point and result transactions of the circle fit
// checker unit, predicts each set's result and compares it field by field.
//----------------------------------------------------------------------------
module circle_fit_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [cfc_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [cfc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // point_x, point_y
  input  logic [cfc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  input  logic                                s_axis_tlast,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // center_x2, center_y2, radius_q8, mean_deviation_q8
  input  logic [cfc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // status
  input  logic [cfc_pkg::OUT_USER_BITS-1:0]   m_axis_tuser,
  output int                                  fail_count,
  output int                                  pending
);
  import cfc_pkg::*;

  localparam logic [63:0] SUM_FULL  = (64'd1 << SUM_BITS) - 64'd1;
  localparam logic [63:0] MEAN_FULL = (64'd1 << MEAN_BITS) - 64'd1;

  logic [63:0] rect_l, rect_t, rect_r, rect_b, rel_q14, mindev_q8;
  logic [63:0] dev_sum, seen;
  res_t        expected_fits[$];
  int          errors = 0;

  function automatic logic [63:0] span_between(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic absorb_point(input logic [63:0] px, input logic [63:0] py, input logic last);
    logic [63:0] cx2, cy2, w, h, dx, dy, radicand, root, cand, rad, dev, mean;
    logic        wide_ok, high_ok, over_rel, over_min;
    res_t        fit;
    int          b;
    cx2     = rect_l + rect_r;
    cy2     = rect_t + rect_b;
    w       = rect_r - rect_l;
    h       = rect_b - rect_t;
    rad     = (w + h) << (FRAC_BITS - 2);
    wide_ok = rect_r > rect_l + 1;
    high_ok = rect_b > rect_t + 1;
    if (wide_ok && high_ok) begin
      dx       = span_between(cx2, px << 1);
      dy       = span_between(cy2, py << 1);
      radicand = (dx * dx + dy * dy) << (2 * (FRAC_BITS - 1));
      root     = '0;
      for (b = ROOT_BITS; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= radicand) root = cand;
      end
      dev     = span_between(root, rad);
      dev_sum = (SUM_FULL - dev_sum < dev) ? SUM_FULL : dev_sum + dev;
    end
    if (seen <= MAX_POINTS) seen++;
    if (last) begin
      fit.cx2    = cx2[C2_BITS-1:0];
      fit.cy2    = cy2[C2_BITS-1:0];
      fit.radius = '0;
      fit.mean   = '0;
      if (seen > MAX_POINTS) begin
        fit.status = ST_MANY;
      end else if (seen < MIN_SET_POINTS || !wide_ok || !high_ok) begin
        fit.status = ST_FEW;
      end else begin
        mean       = dev_sum / seen;
        over_rel   = (mean << (REL_FRAC + 1)) > ((rel_q14 * (w + h + 2)) << FRAC_BITS);
        over_min   = (mean << MINDEV_FRAC) > (mindev_q8 << FRAC_BITS);
        fit.status = (over_rel && over_min) ? ST_OVER : ST_FIT;
        if (mean > MEAN_FULL) mean = MEAN_FULL;
        fit.radius = rad[RAD_BITS-1:0];
        fit.mean   = mean[MEAN_BITS-1:0];
      end
      expected_fits.push_back(fit);
      dev_sum = '0;
      seen    = '0;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      rect_l    = '0;
      rect_t    = '0;
      rect_r    = '0;
      rect_b    = '0;
      rel_q14   = REL_LIMIT_RESET;
      mindev_q8 = '0;
      dev_sum   = '0;
      seen      = '0;
      expected_fits.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_fits.size() == 0) begin
          $error("result transaction with no point set outstanding");
          errors++;
        end else begin
          want = expected_fits.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("center_x2", want.cx2, m_axis_tdata[0 +: C2_BITS]);
          check_field("center_y2", want.cy2, m_axis_tdata[C2_BITS +: C2_BITS]);
          check_field("radius_q8", want.radius, m_axis_tdata[2*C2_BITS +: RAD_BITS]);
          check_field("mean_deviation_q8", want.mean,
                      m_axis_tdata[2*C2_BITS+RAD_BITS +: MEAN_BITS]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_point(s_axis_tdata[COORD_BITS-1:0],
                     s_axis_tdata[2*COORD_BITS-1:COORD_BITS], s_axis_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT:   rect_l    = cfg_data[COORD_BITS-1:0];
          REG_TOP:    rect_t    = cfg_data[COORD_BITS-1:0];
          REG_RIGHT:  rect_r    = cfg_data[COORD_BITS-1:0];
          REG_BOTTOM: rect_b    = cfg_data[COORD_BITS-1:0];
          REG_REL:    rel_q14   = cfg_data[REL_BITS-1:0];
          REG_MINDEV: mindev_q8 = cfg_data[MINDEV_BITS-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= expected_fits.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
//----------------------------------------------------------------------------
// Circle fit checker unit testbench
// Writes the rectangle and limit registers, streams edge point sets at
// varying source and sink pacing and leaves prediction to the result checker.
//----------------------------------------------------------------------------
module testbench;
  import cfc_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 8000000;
  localparam int RANDOM_POINTS   = 1650;
  localparam int HOLD_CYCLES     = 1500;
  localparam int SETTLE_CYCLES   = 100;
  localparam int OVERFLOW_POINTS = MAX_POINTS + 4;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
  localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {PACE_STEADY, PACE_SOURCE_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     cfg_valid     = 1'b0;
  logic                     cfg_ready;
  logic [IDX_BITS-1:0]      cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data      = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tlast  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [OUT_USER_BITS-1:0] m_axis_tuser;

  int fail_count;
  int pending;
  int source_idle_pct = 0;
  int sink_stall_pct  = 0;
  int hold_req        = 0;
  int hold_ack        = 0;
  int hold_left       = 0;
  int cycle_count;
  int geo_l, geo_t, geo_r, geo_b;

  circle_fit_checker_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  circle_fit_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_STEADY:      begin source_idle_pct = 0;  sink_stall_pct = 0;  end
      PACE_SOURCE_GAPS: begin source_idle_pct = 76; sink_stall_pct = 0;  end
      PACE_SINK_STALLS: begin source_idle_pct = 0;  sink_stall_pct = 76; end
      default:          begin source_idle_pct = 24; sink_stall_pct = 24; end
    endcase
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drop the point stream and wait for every outstanding result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_unit(input int l, input int t, input int r, input int b,
                              input int rel, input int mindev);
    logic [31:0] pad;
    logic [31:0] pad_rel;
    settle();
    pad     = $urandom;
    pad_rel = $urandom;
    write_reg(REG_LEFT,   {pad[7:0],     l[15:0]});
    write_reg(REG_TOP,    {pad[15:8],    t[15:0]});
    write_reg(REG_RIGHT,  {pad[23:16],   r[15:0]});
    write_reg(REG_BOTTOM, {pad[31:24],   b[15:0]});
    write_reg(REG_REL,    {pad_rel[7:0], rel[15:0]});
    write_reg(REG_MINDEV, mindev[23:0]);
    cfg_valid <= 1'b0;
    geo_l = l;
    geo_t = t;
    geo_r = r;
    geo_b = b;
  endtask

  task automatic send_point(input logic [15:0] px, input logic [15:0] py, input logic last);
    while (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // points on the rectangle's inscribed ellipse with jitter, or scattered anywhere
  task automatic send_set(input int n, input int amp, input bit scatter);
    real cx, cy, rx, ry, ang;
    int  i, x, y, jit_x, jit_y;
    cx = (geo_l + geo_r) / 2.0;
    cy = (geo_t + geo_b) / 2.0;
    rx = (geo_r - geo_l) / 2.0;
    ry = (geo_b - geo_t) / 2.0;
    for (i = 0; i < n; i++) begin
      if (scatter) begin
        x = $urandom_range(COORD_MAX);
        y = $urandom_range(COORD_MAX);
      end else begin
        ang   = $urandom_range(62831) / 10000.0;
        jit_x = $urandom_range(2 * amp);
        jit_y = $urandom_range(2 * amp);
        x     = $rtoi(cx + rx * $cos(ang)) + jit_x - amp;
        y     = $rtoi(cy + ry * $sin(ang)) + jit_y - amp;
        if (x < 0) x = 0;
        if (x > COORD_MAX) x = COORD_MAX;
        if (y < 0) y = 0;
        if (y > COORD_MAX) y = COORD_MAX;
      end
      send_point(x[15:0], y[15:0], i == n - 1);
    end
  endtask

  initial begin
    logic [15:0] rim_x [8];
    logic [15:0] rim_y [8];
    int          i, k, n, amp, l, t, r, b, rel, mindev, shape, random_points, group, sets;
    rim_x = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd32767, 16'd0, 16'd65535, 16'd32768};
    rim_y = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd32768, 16'd32767, 16'd65535};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_pace(PACE_STEADY);

    // zero-sized rectangle from reset, single point
    send_point(16'hAAAA, 16'h5555, 1'b1);
    settle();
    write_reg(REG_SPARE_LO, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;

    // full-range rectangle, loosest then tightest limits
    for (k = 0; k < 2; k++) begin
      program_unit(0, 0, COORD_MAX, COORD_MAX, (k == 0) ? 65535 : 0,
                   (k == 0) ? 24'hFFFFFF : 0);
      for (i = 0; i < 8; i++) send_point(rim_x[i], rim_y[i], i == 7);
    end

    // reversed width
    program_unit(500, 200, 400, 900, REL_LIMIT_RESET, 0);
    send_point(16'd450, 16'd550, 1'b1);

    // width of one pixel
    program_unit(100, 200, 101, 900, REL_LIMIT_RESET, 0);
    send_point(16'd100, 16'd550, 1'b1);

    // one point short of a set
    program_unit(1000, 1000, 1064, 1064, REL_LIMIT_RESET, 0);
    send_set(MIN_SET_POINTS - 1, 2, 1'b0);

    // point count overflow
    program_unit(20000, 30000, 20200, 30180, REL_LIMIT_RESET, 0);
    send_set(OVERFLOW_POINTS, 3, 1'b0);

    random_points = 0;
    group         = 0;
    while (random_points < RANDOM_POINTS) begin
      shape = $urandom_range(99);
      if (shape < 5) begin
        l = $urandom_range(100, COORD_MAX - 3100);
        r = l - 3 + $urandom_range(4);
        t = $urandom_range(0, COORD_MAX - 3000);
        b = t + $urandom_range(2, 3000);
      end else if (shape < 10) begin
        t = $urandom_range(100, COORD_MAX - 3100);
        b = t - 3 + $urandom_range(4);
        l = $urandom_range(0, COORD_MAX - 3000);
        r = l + $urandom_range(2, 3000);
      end else if (shape < 22) begin
        l = $urandom_range(0, 1500);
        r = $urandom_range(COORD_MAX - 1500, COORD_MAX);
        t = $urandom_range(0, 1500);
        b = $urandom_range(COORD_MAX - 1500, COORD_MAX);
      end else begin
        n = $urandom_range(2, ($urandom_range(3) == 0) ? 8000 : 300);
        l = $urandom_range(0, COORD_MAX - n);
        r = l + n;
        if ($urandom_range(2) == 0) n = $urandom_range(2, 300);
        t = $urandom_range(0, COORD_MAX - n);
        b = t + n;
      end
      case ($urandom_range(9))
        0:       rel = 0;
        1:       rel = 65535;
        2, 3:    rel = REL_LIMIT_RESET;
        default: rel = $urandom_range(4000);
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: mindev = 0;
        4:          mindev = 24'hFFFFFF;
        default:    mindev = $urandom_range(2048);
      endcase
      program_unit(l, t, r, b, rel, mindev);
      set_pace(pace_t'(group % 4));
      if (group == 2) begin
        // hold the sink off so the unit backs up onto the point stream
        hold_req <= hold_req + 1;
        sets = 4;
      end else begin
        sets = $urandom_range(1, 5);
      end
      for (k = 0; k < sets; k++) begin
        case ($urandom_range(19))
          0, 1:    n = $urandom_range(1, MIN_SET_POINTS - 1);
          2:       n = MIN_SET_POINTS;
          3, 4:    n = $urandom_range(41, 120);
          default: n = $urandom_range(9, 40);
        endcase
        if (group == 2) n = MIN_SET_POINTS;
        case ($urandom_range(7))
          0:       amp = 0;
          1, 2:    amp = $urandom_range(1, 3);
          3, 4, 5: amp = $urandom_range(4, 40);
          default: amp = $urandom_range(41, 2000);
        endcase
        send_set(n, amp, $urandom_range(9) == 0);
        random_points += n;
      end
      group++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
